// ----- rtl/line_follow_speed_ramp_controller_macros.svh -----
// Assertion macros shared by the line follower checker.
// No dependencies; included by lfsrc_checker.sv.
`ifndef LINE_FOLLOW_SPEED_RAMP_CONTROLLER_MACROS_SVH
`define LINE_FOLLOW_SPEED_RAMP_CONTROLLER_MACROS_SVH

// same-cycle implication, masked during reset
`define LFSRC_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lfsrc check failed");

// next-cycle implication, masked during reset
`define LFSRC_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lfsrc check failed");

`endif

// ----- rtl/lfsrc_pkg.sv -----
// Types and constants for the line follower speed ramp controller.
// No dependencies; used by every other file of the block but the macro header.
`default_nettype none

package lfsrc_pkg;

    typedef enum logic [1:0] {
        DIR_MID   = 2'd0,
        DIR_LEFT  = 2'd1,
        DIR_RIGHT = 2'd2
    } dir_t;

    // configuration register indexes
    localparam logic [1:0] CFG_BASE_DUTY    = 2'd0;
    localparam logic [1:0] CFG_TURN_CONFIRM = 2'd1;
    localparam logic [1:0] CFG_LAP_TICKS    = 2'd2;
    localparam logic [1:0] CFG_PAUSE_TICKS  = 2'd3;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [14:0] BASE_DUTY_RST    = 15'd1000;
    localparam logic [15:0] TURN_CONFIRM_RST = 16'd500;
    localparam logic [15:0] LAP_TICKS_RST    = 16'd4000;
    localparam logic [15:0] PAUSE_TICKS_RST  = 16'd1000;

    // sensor flag / ack bit positions
    localparam int FLAG_RIGHT = 0;
    localparam int FLAG_LEFT  = 1;
    localparam int FLAG_MID   = 2;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic       mode;
        logic [2:0] sensor_flags;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  direction_out;
        logic [15:0] duty;
        logic        pausing;
        logic [2:0]  edge_bits;
        logic [2:0]  flag_acked;
    } out_item_t;

    // classified operation handed from front to back
    typedef struct packed {
        logic       is_tick;
        logic       dir_load;
        dir_t       dir_new;
        logic [2:0] ack;
    } op_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

endpackage

`default_nettype wire

// ----- rtl/lfsrc_queue.sv -----
// Two-entry operation queue between front and back.
// Depends on lfsrc_pkg.
`default_nettype none

module lfsrc_queue (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire lfsrc_pkg::op_t   push_op,
    input  wire logic             pop,
    output lfsrc_pkg::op_t        head_op,
    output lfsrc_pkg::q_status_t  status
);

    lfsrc_pkg::op_t                      entries_reg [lfsrc_pkg::QUEUE_DEPTH];
    logic [lfsrc_pkg::QPTR_W-1:0]        wr_ptr_reg, wr_ptr_next;
    logic [lfsrc_pkg::QPTR_W-1:0]        rd_ptr_reg, rd_ptr_next;
    logic [lfsrc_pkg::QCNT_W-1:0]        count_reg, count_next;

    localparam logic [lfsrc_pkg::QCNT_W-1:0] FULL_CNT =
        lfsrc_pkg::QCNT_W'(lfsrc_pkg::QUEUE_DEPTH);
    localparam logic [lfsrc_pkg::QPTR_W-1:0] LAST_PTR =
        lfsrc_pkg::QPTR_W'(lfsrc_pkg::QUEUE_DEPTH - 1);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries_reg[wr_ptr_reg] <= push_op;
        end
    end

    assign head_op      = entries_reg[rd_ptr_reg];
    assign status.full  = (count_reg == FULL_CNT);
    assign status.empty = (count_reg == '0);

endmodule

`default_nettype wire

// ----- rtl/lfsrc_front.sv -----
// Front end: takes input items and classifies them into queue operations.
// Depends on lfsrc_pkg.
`default_nettype none

module lfsrc_front (
    input  wire logic                 item_valid,
    output logic                      item_stall,
    input  wire lfsrc_pkg::in_item_t  item,
    input  wire lfsrc_pkg::q_status_t q_status,
    output logic                      push,
    output lfsrc_pkg::op_t            push_op
);

    assign item_stall = q_status.full;
    assign push       = item_valid && !q_status.full;

    // priority: right, then left, then middle
    always_comb
    begin
        push_op.is_tick  = item.mode;
        push_op.dir_load = 1'b0;
        push_op.dir_new  = lfsrc_pkg::DIR_MID;
        push_op.ack      = '0;
        if (!item.mode)
        begin
            if (item.sensor_flags[lfsrc_pkg::FLAG_RIGHT])
            begin
                push_op.dir_load = 1'b1;
                push_op.dir_new  = lfsrc_pkg::DIR_RIGHT;
                push_op.ack[lfsrc_pkg::FLAG_RIGHT] = 1'b1;
            end
            else if (item.sensor_flags[lfsrc_pkg::FLAG_LEFT])
            begin
                push_op.dir_load = 1'b1;
                push_op.dir_new  = lfsrc_pkg::DIR_LEFT;
                push_op.ack[lfsrc_pkg::FLAG_LEFT] = 1'b1;
            end
            else if (item.sensor_flags[lfsrc_pkg::FLAG_MID])
            begin
                push_op.dir_load = 1'b1;
                push_op.dir_new  = lfsrc_pkg::DIR_MID;
                push_op.ack[lfsrc_pkg::FLAG_MID] = 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

// ----- rtl/lfsrc_back.sv -----
// Back end: configuration registers, controller state and result register.
// Depends on lfsrc_pkg.
`default_nettype none

module lfsrc_back (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_we,
    input  wire logic [lfsrc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [lfsrc_pkg::CFG_DATA_W-1:0] cfg_data,
    input  wire lfsrc_pkg::op_t                   head_op,
    input  wire lfsrc_pkg::q_status_t             q_status,
    output logic                                  pop,
    output logic                                  result_valid,
    input  wire logic                             result_stall,
    output lfsrc_pkg::out_item_t                  result
);

    logic [14:0] base_duty_reg;
    logic [15:0] turn_confirm_reg, lap_ticks_reg, pause_ticks_reg;

    lfsrc_pkg::dir_t direction_reg, direction_next;
    lfsrc_pkg::dir_t confirmed_reg, confirmed_next;
    logic [15:0]     turn_count_reg, turn_count_next;
    logic [15:0]     straight_count_reg, straight_count_next;
    logic [15:0]     pause_count_reg, pause_count_next;
    logic [15:0]     drive_duty_reg, drive_duty_next;
    logic            pause_flag_reg, pause_flag_next;
    logic [2:0]      edge_select_reg, edge_select_next;

    logic                 result_valid_reg, result_valid_next;
    lfsrc_pkg::out_item_t result_reg, result_next;

    logic [15:0] base16;
    logic [15:0] step;

    function automatic logic [15:0] sat_inc(input logic [15:0] v);
        return (v == 16'hFFFF) ? v : v + 16'd1;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_duty_reg    <= lfsrc_pkg::BASE_DUTY_RST;
            turn_confirm_reg <= lfsrc_pkg::TURN_CONFIRM_RST;
            lap_ticks_reg    <= lfsrc_pkg::LAP_TICKS_RST;
            pause_ticks_reg  <= lfsrc_pkg::PAUSE_TICKS_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                lfsrc_pkg::CFG_BASE_DUTY:    base_duty_reg    <= cfg_data[14:0];
                lfsrc_pkg::CFG_TURN_CONFIRM: turn_confirm_reg <= cfg_data;
                lfsrc_pkg::CFG_LAP_TICKS:    lap_ticks_reg    <= cfg_data;
                lfsrc_pkg::CFG_PAUSE_TICKS:  pause_ticks_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    // a new op runs when the result register is free or being emptied
    assign pop    = !q_status.empty && (!result_valid_reg || !result_stall);
    assign base16 = {1'b0, base_duty_reg};

    always_comb
    begin
        direction_next      = direction_reg;
        confirmed_next      = confirmed_reg;
        turn_count_next     = turn_count_reg;
        straight_count_next = straight_count_reg;
        pause_count_next    = pause_count_reg;
        drive_duty_next     = drive_duty_reg;
        pause_flag_next     = pause_flag_reg;
        edge_select_next    = edge_select_reg;
        step                = '0;

        if (head_op.is_tick)
        begin
            if (confirmed_reg != direction_reg && turn_count_reg > turn_confirm_reg)
            begin
                turn_count_next     = '0;
                straight_count_next = '0;
                confirmed_next      = direction_reg;
                drive_duty_next     = base16;
            end
            if (direction_reg == lfsrc_pkg::DIR_LEFT ||
                direction_reg == lfsrc_pkg::DIR_RIGHT)
            begin
                turn_count_next = sat_inc(turn_count_next);
            end
            if (direction_reg == lfsrc_pkg::DIR_MID)
            begin
                turn_count_next     = '0;
                straight_count_next = sat_inc(straight_count_next);
                step = (straight_count_next > base16) ? base16 : straight_count_next;
                drive_duty_next = base16 + step;
            end
            if (straight_count_next > lap_ticks_reg)
            begin
                drive_duty_next = '0;
                pause_flag_next = 1'b1;
            end
            if (pause_flag_next)
            begin
                pause_count_next = sat_inc(pause_count_next);
            end
            if (pause_count_next > pause_ticks_reg)
            begin
                pause_flag_next     = 1'b0;
                straight_count_next = '0;
                pause_count_next    = '0;
            end
        end
        else
        begin
            if (head_op.dir_load)
            begin
                direction_next = head_op.dir_new;
            end
            edge_select_next = edge_select_reg ^ head_op.ack;
        end

        result_next.direction_out = direction_next;
        result_next.duty          = drive_duty_next;
        result_next.pausing       = pause_flag_next;
        result_next.edge_bits     = edge_select_next;
        result_next.flag_acked    = head_op.is_tick ? 3'b000 : head_op.ack;

        if (pop)
        begin
            result_valid_next = 1'b1;
        end
        else
        begin
            result_valid_next = result_valid_reg && result_stall;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            direction_reg      <= lfsrc_pkg::DIR_MID;
            confirmed_reg      <= lfsrc_pkg::DIR_MID;
            turn_count_reg     <= '0;
            straight_count_reg <= '0;
            pause_count_reg    <= '0;
            drive_duty_reg     <= '0;
            pause_flag_reg     <= 1'b0;
            edge_select_reg    <= '0;
            result_valid_reg   <= 1'b0;
        end
        else
        begin
            result_valid_reg <= result_valid_next;
            if (pop)
            begin
                direction_reg      <= direction_next;
                confirmed_reg      <= confirmed_next;
                turn_count_reg     <= turn_count_next;
                straight_count_reg <= straight_count_next;
                pause_count_reg    <= pause_count_next;
                drive_duty_reg     <= drive_duty_next;
                pause_flag_reg     <= pause_flag_next;
                edge_select_reg    <= edge_select_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            result_reg <= result_next;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

`default_nettype wire

// ----- rtl/line_follow_speed_ramp_controller.sv -----
// Line follower speed ramp controller: sensor events pick a direction, timer
// ticks confirm turns, ramp the motor duty on straights and run a lap pause.
// Sustained rate is one item per clock while result_stall is low. An
// accepted item is decoded in the front end, held in a two-entry queue and
// executed by the back end; its result is registered in the output register
// when the back end pops it from the queue. item_stall rises only once the
// queue holds two items, so up to three items (two queued, one in the output
// register) can wait while the result side stalls.
// Configuration writes take effect at the next edge.
`default_nettype none

module line_follow_speed_ramp_controller (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_we,
    input  wire logic [lfsrc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [lfsrc_pkg::CFG_DATA_W-1:0] cfg_data,
    input  wire logic                             item_valid,
    output logic                                  item_stall,
    input  wire lfsrc_pkg::in_item_t              item,
    output logic                                  result_valid,
    input  wire logic                             result_stall,
    output lfsrc_pkg::out_item_t                  result
);

    logic                 push;
    logic                 pop;
    lfsrc_pkg::op_t       push_op;
    lfsrc_pkg::op_t       head_op;
    lfsrc_pkg::q_status_t q_status;

    lfsrc_front u_front (
        .item_valid (item_valid),
        .item_stall (item_stall),
        .item       (item),
        .q_status   (q_status),
        .push       (push),
        .push_op    (push_op)
    );

    lfsrc_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .push_op (push_op),
        .pop     (pop),
        .head_op (head_op),
        .status  (q_status)
    );

    lfsrc_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .head_op      (head_op),
        .q_status     (q_status),
        .pop          (pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule

`default_nettype wire

// ----- rtl/lfsrc_checker.sv -----
// Port-level checks for the line follower controller, bound to the top level.
// Depends on lfsrc_pkg and line_follow_speed_ramp_controller_macros.svh.
`default_nettype none
`include "line_follow_speed_ramp_controller_macros.svh"

module lfsrc_checker (
    input wire logic                             clk,
    input wire logic                             rst_n,
    input wire logic                             result_valid,
    input wire logic                             result_stall,
    input wire lfsrc_pkg::out_item_t             result
);

    logic res_held;
    logic ack_right;
    logic ack_left;
    logic turning_right;
    logic turning_left;

    assign res_held      = result_valid && result_stall;
    assign ack_right     = result_valid && result.flag_acked[lfsrc_pkg::FLAG_RIGHT];
    assign ack_left      = result_valid && result.flag_acked[lfsrc_pkg::FLAG_LEFT];
    assign turning_right = (result.direction_out == lfsrc_pkg::DIR_RIGHT);
    assign turning_left  = (result.direction_out == lfsrc_pkg::DIR_LEFT);

    // a stalled result holds
    `LFSRC_ASSERT_NXT(a_result_hold, clk, rst_n, res_held, result_valid && $stable(result))

    // at most one flag acknowledged per event
    `LFSRC_ASSERT_IMP(a_ack_onehot, clk, rst_n, result_valid, $onehot0(result.flag_acked))

    // an acknowledged right flag always leaves the car turning right
    `LFSRC_ASSERT_IMP(a_ack_right, clk, rst_n, ack_right, turning_right)

    // an acknowledged left flag always leaves the car turning left
    `LFSRC_ASSERT_IMP(a_ack_left, clk, rst_n, ack_left, turning_left)

endmodule

bind line_follow_speed_ramp_controller lfsrc_checker u_lfsrc_checker (.*);

`default_nettype wire
